>>> src/wto_pkg.sv
// Shared package for the wavetable oscillator with vibrato.
// Holds field widths, register and request codes, defaults and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package wto_pkg;

	localparam int TABLE_DEPTH_DEF    = 4096;
	localparam int VIBRATO_PERIOD_DEF = 4096;

	localparam int WORD_W     = 32;
	localparam int IDX_W      = 12;
	localparam int LEN_W      = 13;
	localparam int FRAC_W     = 11;
	localparam int CFG_IDX_W  = 2;
	// Divider remainder and divisor hold up to 65536, the largest table depth.
	localparam int REM_W      = 17;
	localparam int DCNT_W     = 6;
	localparam logic [DCNT_W-1:0] PASS_LEN_STEPS   = DCNT_W'(WORD_W);
	localparam logic [DCNT_W-1:0] PASS_DEPTH_STEPS = DCNT_W'(REM_W);

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIBRATO_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LENGTH  = 2'd2;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [LEN_W-1:0] WAVE_LENGTH_RST = 13'd4096;

	typedef struct packed {
		logic wr_table;      // store the input word in the table
		logic start_sample;  // advance phase, load divider with length pass
		logic div_step;      // one restoring-division step
		logic start_reduce;  // reload divider for the table-depth pass
		logic read_mem;      // read table at the reduced index
		logic load_out;      // move read word to the output register
	} wto_cmd_t;

	typedef struct packed {
		logic div_last;      // current step is the last of the pass
		logic rem_ge_depth;  // remainder still outside the table
		logic out_full;      // output register cannot take a word
	} wto_stat_t;

endpackage

>>> src/wavetable_oscillator_vibrato.sv
// Top level of the wavetable oscillator with square-wave vibrato.
// Instantiates wto_ctrl and wto_dp; depends on wto_pkg.
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// in       in_valid / in_ready      req_type, table_index, table_value
// out      out_valid / out_ready    sample
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A table-write word is stored in the table and the block stays ready for more.
// A sample word passes through the phase add at acceptance, 32 steps of the
// bit-serial remainder unit that reduces the phase index by the table length,
// a check state that also starts the table read, and a read state that moves
// the read word to the output register.
// When the length exceeds the table depth and the index lands past the table,
// a second pass of 17 steps plus a check state reduces it by the depth.
// The input reopens as the result enters the output register, so no new word
// is taken while a sample is in progress; a stalled output holds the block in
// its read state until the waiting word is taken.
// Reset clears the phase, vibrato counter and sign and loads register defaults;
// the table memory is not cleared and holds no valid data until written.
// The configuration port is always ready; writes belong in idle periods.

module wavetable_oscillator_vibrato
	import wto_pkg::*;
#(
	parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
	parameter int VIBRATO_PERIOD = VIBRATO_PERIOD_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [IDX_W-1:0]         table_index,
	input  logic signed [WORD_W-1:0] table_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] sample,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]        cfg_data
);

	wto_cmd_t  cmd;
	wto_stat_t stat;

	// Registers are plain flops, so the port never stalls.
	assign cfg_ready = 1'b1;

	wto_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wto_dp #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.VIBRATO_PERIOD (VIBRATO_PERIOD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.table_index (table_index),
		.table_value (table_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample)
	);

endmodule

>>> src/wto_ctrl.sv
// Sequencing state machine of the wavetable oscillator.
// Depends on wto_pkg for command and status structs and request codes.
`timescale 1ns / 1ps

module wto_ctrl
	import wto_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      req_type,
	output logic      in_ready,
	input  wto_stat_t stat,
	output wto_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_READ = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_SAMPLE) begin
						cmd.start_sample = 1'b1;
						state_d          = ST_DIV;
					end else begin
						cmd.wr_table = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.rem_ge_depth) begin
					cmd.start_reduce = 1'b1;
					state_d          = ST_DIV;
				end else begin
					cmd.read_mem = 1'b1;
					state_d      = ST_READ;
				end
			end
			ST_READ: begin
				if (!stat.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/wto_dp.sv
// Datapath of the wavetable oscillator: registers, phase accumulator,
// vibrato counter, bit-serial remainder unit, table memory, output word.
// Depends on wto_pkg.
`timescale 1ns / 1ps

module wto_dp
	import wto_pkg::*;
#(
	parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
	parameter int VIBRATO_PERIOD = VIBRATO_PERIOD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wto_cmd_t             cmd,
	output wto_stat_t            stat,
	input  logic [IDX_W-1:0]     table_index,
	input  logic signed [WORD_W-1:0] table_value,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [WORD_W-1:0] sample
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(VIBRATO_PERIOD);
	localparam logic [REM_W-1:0] DEPTH_V  = REM_W'(TABLE_DEPTH);
	localparam logic [CW-1:0]    CNT_LAST = CW'(VIBRATO_PERIOD - 1);

	logic [WORD_W-1:0] phase_step_q, vibrato_step_q;
	logic [LEN_W-1:0]  wave_length_q;
	logic [WORD_W-1:0] phase_acc_q;
	logic [CW-1:0]     sample_cnt_q;
	logic              vib_neg_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] dvd_q;
	logic [REM_W-1:0]  rem_q, dvs_q;
	logic [WORD_W-1:0] rd_q, sample_q;

	logic [WORD_W-1:0] mem [TABLE_DEPTH];

	// Phase update for the sample being started.
	logic              vib_neg_d;
	logic [WORD_W-1:0] vib_off, phase_acc_d, int_part;

	assign vib_neg_d   = vib_neg_q ^ (sample_cnt_q == '0);
	assign vib_off     = vib_neg_d ? (WORD_W'(0) - vibrato_step_q) : vibrato_step_q;
	assign phase_acc_d = phase_acc_q + phase_step_q + vib_off;
	assign int_part    = {{FRAC_W{phase_acc_d[WORD_W-1]}}, phase_acc_d[WORD_W-1:FRAC_W]};

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	logic [REM_W:0]   trial;
	logic             fits;
	logic [REM_W-1:0] rem_d;

	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign rem_d = fits ? REM_W'(trial - {1'b0, dvs_q}) : trial[REM_W-1:0];

	logic len_zero;
	assign len_zero = (wave_length_q == '0);

	assign stat.div_last     = (dcnt_q == DCNT_W'(1));
	assign stat.rem_ge_depth = !len_zero && (rem_q >= DEPTH_V);
	assign stat.out_full     = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			vibrato_step_q <= '0;
			wave_length_q  <= WAVE_LENGTH_RST;
			phase_acc_q    <= '0;
			sample_cnt_q   <= '0;
			vib_neg_q      <= 1'b0;
			dcnt_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PHASE_STEP:   phase_step_q   <= cfg_data;
					CFG_VIBRATO_STEP: vibrato_step_q <= cfg_data;
					CFG_WAVE_LENGTH:  wave_length_q  <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start_sample) begin
				phase_acc_q  <= phase_acc_d;
				vib_neg_q    <= vib_neg_d;
				sample_cnt_q <= (sample_cnt_q == CNT_LAST) ? '0 : sample_cnt_q + CW'(1);
				dcnt_q       <= PASS_LEN_STEPS;
			end else if (cmd.start_reduce) begin
				dcnt_q <= PASS_DEPTH_STEPS;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_sample) begin
			dvd_q <= int_part;
			rem_q <= '0;
			dvs_q <= REM_W'(wave_length_q);
		end else if (cmd.start_reduce) begin
			dvd_q <= {rem_q, (WORD_W - REM_W)'(0)};
			rem_q <= '0;
			dvs_q <= DEPTH_V;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
		if (cmd.load_out) begin
			sample_q <= rd_q;
		end
	end

	// Table memory: one write port, one registered read port.
	logic [REM_W-1:0] wr_idx_ext;
	logic [AW-1:0]    rd_addr;

	assign wr_idx_ext = REM_W'(table_index);
	assign rd_addr    = len_zero ? '0 : rem_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_table && (wr_idx_ext < DEPTH_V)) begin
			mem[wr_idx_ext[AW-1:0]] <= table_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_mem) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

>>> src/wto_checker.sv
// Port-level checks for the wavetable oscillator, bound to the top level.
// Depends on wto_pkg for widths and request codes.
`timescale 1ns / 1ps

module wto_checker
	import wto_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     req_type,
	input logic [IDX_W-1:0]         table_index,
	input logic signed [WORD_W-1:0] table_value,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [WORD_W-1:0] sample,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic [CFG_IDX_W-1:0]     cfg_index,
	input logic [WORD_W-1:0]        cfg_data
);

	// A waiting output word stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("output word changed while stalled");

	// A table write never produces an output word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_WRITE) && !out_valid |=> !out_valid)
		else $error("table write produced an output word");

	// A sample word keeps the input closed while it is computed.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_SAMPLE) |=> !in_ready)
		else $error("input reopened right after a sample word");

	// A result never appears in the cycle after its sample is taken.
	a_sample_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_SAMPLE) && !out_valid |=> !out_valid)
		else $error("output word appeared too early");

endmodule

bind wavetable_oscillator_vibrato wto_checker u_chk (.*);
